// ===== rtl/core/ssc_pkg.sv =====
// Shared types and constants for the substring occurrence counter.
// No dependencies; imported by ssc_cell and substring_occurrence_counter.
package ssc_pkg;

  // default sizes for the top-level parameters
  localparam int unsigned MaxPatternDefault = 32;
  localparam int unsigned CountBitsDefault  = 16;

  // width of the count field on the result port
  localparam int unsigned OutCountW = 16;

  // operation codes carried by a transaction
  localparam logic OpPattern = 1'b0;
  localparam logic OpText    = 1'b1;

  // shift enables handed to every cell of the chain
  typedef struct packed {
    logic pat_shift;
    logic win_shift;
  } ssc_ctrl_t;

endpackage

// ===== rtl/core/ssc_cell.sv =====
// One cell of the comparison chain: holds one pattern byte and one window byte.
// Depends on ssc_pkg for the control struct.
module ssc_cell
  import ssc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  ssc_ctrl_t  ctrl_i,
  input  logic [7:0] pat_i,
  input  logic       pval_i,
  input  logic [7:0] win_i,
  input  logic       wval_i,
  output logic [7:0] pat_o,
  output logic       pval_o,
  output logic [7:0] win_o,
  output logic       wval_o,
  output logic       ok_o
);

  logic [7:0] pat_q;
  logic       pval_q;
  logic [7:0] win_q;
  logic       wval_q;

  // valid bits of both chains
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pval_q <= 1'b0;
      wval_q <= 1'b0;
    end else begin
      if (ctrl_i.pat_shift) begin
        pval_q <= pval_i;
      end
      if (ctrl_i.win_shift) begin
        wval_q <= wval_i;
      end
    end
  end

  // byte registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (ctrl_i.pat_shift) begin
      pat_q <= pat_i;
    end
    if (ctrl_i.win_shift) begin
      win_q <= win_i;
    end
  end

  // compare the byte entering this cell with the held pattern byte
  assign ok_o = !pval_q || (wval_i && (win_i == pat_q));

  assign pat_o  = pat_q;
  assign pval_o = pval_q;
  assign win_o  = win_q;
  assign wval_o = wval_q;

endmodule

// ===== rtl/core/substring_occurrence_counter.sv =====
// Substring occurrence counter: a chain of MAX_PATTERN cells compares a text window
// with a loaded pattern. Depends on ssc_pkg and ssc_cell.
//
// Pattern bytes (operation 0) shift into the pattern chain, newest in the first cell,
// and produce no result; first_of_run restarts the pattern and clears the overflow flag.
// A byte that arrives with all MAX_PATTERN cells full is dropped and sets
// pattern_overflow, which disables matching until the next restart. Text bytes
// (operation 1) shift into the window chain; each yields one result with the
// match-ends-here flag, the saturating occurrence count (low 16 bits shown) and the
// echoes of last_of_text and the overflow flag. The per-cell byte compares, their AND
// across the chain and the count increment all happen in the accepting cycle, and the
// result sits in an output register from the next cycle on. A new transaction is taken
// whenever that register is empty or is being drained, so the block sustains one byte
// per clock.
module substring_occurrence_counter
  import ssc_pkg::*;
#(
  parameter int unsigned MAX_PATTERN = MaxPatternDefault,
  parameter int unsigned COUNT_BITS  = CountBitsDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 operation_i,
  input  logic [7:0]           data_byte_i,
  input  logic                 first_of_run_i,
  input  logic                 last_of_text_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic                 match_ends_here_o,
  output logic [OutCountW-1:0] match_count_o,
  output logic                 text_done_o,
  output logic                 pattern_overflow_o
);

  localparam logic [COUNT_BITS-1:0] CountMax = {COUNT_BITS{1'b1}};

  logic                   accept;
  logic                   pat_item;
  logic                   txt_item;
  logic                   pat_full;
  ssc_ctrl_t              ctrl;

  logic [MAX_PATTERN-1:0][7:0] pat_in, pat_out, win_in, win_out;
  logic [MAX_PATTERN-1:0]      pval_in, pval_q, wval_in, wval_q, ok;

  logic                   overflow_q, overflow_d;
  logic [COUNT_BITS-1:0]  cnt_q, cnt_d, cnt_base;
  logic                   hit;

  logic                   out_valid_q;
  logic                   match_q;
  logic [COUNT_BITS-1:0]  count_q;
  logic                   done_q;
  logic                   ovf_out_q;
  logic [COUNT_BITS+OutCountW-1:0] count_ext;

  // handshake
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign pat_item   = accept && (operation_i == OpPattern);
  assign txt_item   = accept && (operation_i == OpText);
  assign pat_full   = pval_q[MAX_PATTERN-1];

  // chain shift enables
  assign ctrl.pat_shift = pat_item && (first_of_run_i || !pat_full);
  assign ctrl.win_shift = txt_item;

  // neighbor inputs, restart clears the valid bits behind the first cell
  always_comb begin
    for (int j = 0; j < MAX_PATTERN; j++) begin
      if (j == 0) begin
        pat_in[j]  = data_byte_i;
        pval_in[j] = 1'b1;
        win_in[j]  = data_byte_i;
        wval_in[j] = 1'b1;
      end else begin
        pat_in[j]  = pat_out[j-1];
        pval_in[j] = !first_of_run_i && pval_q[j-1];
        win_in[j]  = win_out[j-1];
        wval_in[j] = !first_of_run_i && wval_q[j-1];
      end
    end
  end

  // cell chain
  for (genvar g = 0; g < MAX_PATTERN; g++) begin : g_cell
    ssc_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (ctrl),
      .pat_i  (pat_in[g]),
      .pval_i (pval_in[g]),
      .win_i  (win_in[g]),
      .wval_i (wval_in[g]),
      .pat_o  (pat_out[g]),
      .pval_o (pval_q[g]),
      .win_o  (win_out[g]),
      .wval_o (wval_q[g]),
      .ok_o   (ok[g])
    );
  end

  // overflow flag
  always_comb begin
    overflow_d = overflow_q;
    if (pat_item) begin
      if (first_of_run_i) begin
        overflow_d = 1'b0;
      end else if (pat_full) begin
        overflow_d = 1'b1;
      end
    end
  end

  // match decision and saturating count
  assign hit      = !overflow_q && pval_q[0] && (&ok);
  assign cnt_base = first_of_run_i ? '0 : cnt_q;
  assign cnt_d    = (hit && (cnt_base != CountMax)) ? cnt_base + 1'b1 : cnt_base;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      overflow_q  <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      overflow_q <= overflow_d;
      if (txt_item) begin
        cnt_q <= cnt_d;
      end
      if (txt_item) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (txt_item) begin
      match_q   <= hit;
      count_q   <= cnt_d;
      done_q    <= last_of_text_i;
      ovf_out_q <= overflow_q;
    end
  end

  assign count_ext          = {{OutCountW{1'b0}}, count_q};
  assign out_valid_o        = out_valid_q;
  assign match_ends_here_o  = match_q;
  assign match_count_o      = count_ext[OutCountW-1:0];
  assign text_done_o        = done_q;
  assign pattern_overflow_o = ovf_out_q;

  // pattern valid bits form a contiguous run from the first cell
  a_pval_thermo: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((pval_q >> 1) & ~pval_q) == '0)
    else $error("pattern valid bits not contiguous");

  // window valid bits form a contiguous run from the first cell
  a_wval_thermo: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((wval_q >> 1) & ~wval_q) == '0)
    else $error("window valid bits not contiguous");

  // overflow only with a full pattern store
  a_ovf_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    overflow_q |-> pat_full)
    else $error("overflow flag without full pattern");

  // a reported match always leaves a nonzero count
  a_match_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && match_q) |-> (count_q != '0))
    else $error("match reported with zero count");

  // a hit on a text transaction without restart advances an unsaturated count by one
  a_cnt_grow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (txt_item && hit && !first_of_run_i && (cnt_q != CountMax)) |=> (cnt_q == $past(cnt_q) + 1'b1))
    else $error("count did not advance on a hit");

endmodule
